[hw/rtl/next_greater_element_defines.svh]
// assertion macros for the next greater element block
// used by next_greater_element.sv; expects clk and rst_n in scope
`ifndef NEXT_GREATER_ELEMENT_DEFINES_SVH
`define NEXT_GREATER_ELEMENT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define NGE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define NGE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/nge_pkg.sv]
// shared types and constants for the next greater element block
// no dependencies
package nge_pkg;

  localparam int unsigned NGE_STACK_DEPTH = 1024;
  localparam int unsigned NGE_DATA_W      = 32;

  // value reported when no greater element exists
  localparam logic [NGE_DATA_W-1:0] NGE_NONE_VALUE = '1;

  // one request as held in the front queue
  typedef struct packed {
    logic                  start_req;
    logic [NGE_DATA_W-1:0] value;
  } nge_item_t;

  // one result
  typedef struct packed {
    logic                  overflow;
    logic                  has_greater;
    logic [NGE_DATA_W-1:0] greater_value;
  } nge_result_t;

  // front queue status
  typedef struct packed {
    logic q_full;
    logic q_empty;
  } nge_qstat_t;

  // stack engine status
  typedef struct packed {
    logic busy;
    logic stack_empty;
    logic stack_full;
  } nge_bstat_t;

endpackage

[hw/rtl/nge_front.sv]
// front end: accepts requests into a two-entry queue
// depends on nge_pkg
module nge_front
  import nge_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  nge_item_t  in_item,
  output logic       q_valid,
  input  logic       q_ready,
  output nge_item_t  q_item,
  output nge_qstat_t q_stat
);

  nge_item_t  q_mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] fill_r;
  logic       push;
  logic       pop;

  assign in_ready = (fill_r != 2'd2);
  assign q_valid  = (fill_r != 2'd0);
  assign q_item   = q_mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  assign q_stat.q_full  = (fill_r == 2'd2);
  assign q_stat.q_empty = (fill_r == 2'd0);

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= in_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   fill_r <= fill_r + 2'd1;
        2'b01:   fill_r <= fill_r - 2'd1;
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule

[hw/rtl/nge_back.sv]
// back end: monotonic stack engine with result register
// depends on nge_pkg; the stack lives in a single-port-read memory
module nge_back
  import nge_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = NGE_STACK_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_valid,
  output logic        item_ready,
  input  nge_item_t   item,
  output logic        res_valid,
  input  logic        res_ready,
  output nge_result_t res,
  output nge_bstat_t  b_stat
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  typedef enum logic [1:0] {
    S_LOAD,
    S_CMP,
    S_WAIT
  } state_t;

  state_t                state_r;
  logic [CW-1:0]         count_r;
  logic [NGE_DATA_W-1:0] top_r;
  logic [NGE_DATA_W-1:0] val_r;
  logic                  out_valid_r;
  nge_result_t           out_res_r;

  logic [NGE_DATA_W-1:0] stack_mem [STACK_DEPTH];
  logic [NGE_DATA_W-1:0] rd_data_r;
  logic [CW-1:0]         count_m2;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wr_addr;
  logic                  stack_empty;
  logic                  stack_full;
  logic                  do_pop;
  logic                  out_free;
  logic                  finish;
  logic                  push_en;

  assign stack_empty = (count_r == '0);
  assign stack_full  = (count_r == CW'(STACK_DEPTH));
  assign do_pop      = !stack_empty && ($signed(top_r) <= $signed(val_r));
  assign out_free    = !out_valid_r || res_ready;
  assign finish      = (state_r == S_CMP) && !do_pop && out_free;
  assign push_en     = finish && !stack_full;
  assign count_m2    = count_r - CW'(2);
  assign rd_addr     = count_m2[AW-1:0];
  assign wr_addr     = count_r[AW-1:0];

  assign item_ready = (state_r == S_LOAD);
  assign res_valid  = out_valid_r;
  assign res        = out_res_r;

  assign b_stat.busy        = (state_r != S_LOAD);
  assign b_stat.stack_empty = stack_empty;
  assign b_stat.stack_full  = stack_full;

  // stack memory, registered read of the entry under the top
  always_ff @(posedge clk) begin
    if (push_en) begin
      stack_mem[wr_addr] <= val_r;
    end
    rd_data_r <= stack_mem[rd_addr];
  end

  // sequencer: load, pop while top <= value, then report, and push unless the stack is full
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // result register: load on finish, clear when taken
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && res_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_LOAD: begin
          if (item_valid) begin
            val_r <= item.value;
            if (item.start_req) begin
              count_r <= '0;
            end
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          if (do_pop) begin
            count_r <= count_r - CW'(1);
            if (count_r > CW'(1)) begin
              state_r <= S_WAIT;
            end
          end else if (out_free) begin
            out_res_r.has_greater   <= !stack_empty;
            out_res_r.greater_value <= stack_empty ? NGE_NONE_VALUE : top_r;
            out_res_r.overflow      <= stack_full;
            if (!stack_full) begin
              count_r <= count_r + CW'(1);
              top_r   <= val_r;
            end
            state_r <= S_LOAD;
          end
        end
        S_WAIT: begin
          top_r   <= rd_data_r;
          state_r <= S_CMP;
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

endmodule

[hw/rtl/next_greater_element.sv]
// next greater element, monotonic stack: front queue plus stack engine
// depends on nge_pkg, nge_front, nge_back and next_greater_element_defines.svh
//
// usage
//   feed the array from its last element to its first on the in_ stream;
//   in_tuser[0] marks the first element fed and empties the stack.
//   each request gives exactly one result on the out_ stream: the nearest
//   strictly greater element to its right (signed), or -1 with
//   has_greater low, plus an overflow flag when the push found the stack full.
// timing
//   a request with no pops passes the stack engine in a load step and a
//   compare-and-push step; every pop adds a wait step for the registered
//   memory read of the new top and a further compare, and a pop that empties
//   the stack adds only the compare. each element is popped at most once. the
//   engine takes no new request until it has finished the last one.
// reset
//   rst_n low empties the queue and the stack; no memory clearing is needed.
// stalls
//   a held result stays in the output register; the engine waits on it while
//   the two-entry front queue keeps taking requests until it fills.
`include "next_greater_element_defines.svh"

module next_greater_element
  import nge_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = NGE_STACK_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [0:0]  in_tuser,   // [0] start_req
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] greater_value
  output logic [1:0]  out_tuser   // [0] has_greater, [1] overflow
);

  nge_item_t   in_item;
  nge_item_t   q_item;
  nge_qstat_t  q_stat;
  nge_bstat_t  b_stat;
  nge_result_t res;
  logic        q_valid;
  logic        q_ready;

  assign in_item.value     = in_tdata;
  assign in_item.start_req = in_tuser[0];

  // request queue
  nge_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item),
    .q_stat   (q_stat)
  );

  // stack engine
  nge_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (res),
    .b_stat     (b_stat)
  );

  assign out_tdata = res.greater_value;
  assign out_tuser = {res.overflow, res.has_greater};

  // checks
  `NGE_ASSERT_NOW(a_none_is_minus_one, out_tvalid && !out_tuser[0], out_tdata == NGE_NONE_VALUE, "no greater element but value is not -1")
  `NGE_ASSERT_NOW(a_queue_sane, q_stat.q_full, !q_stat.q_empty && !in_tready, "queue full flags inconsistent")
  `NGE_ASSERT_NEXT(a_engine_takes, q_valid && q_ready, b_stat.busy, "engine did not start on a request")
  `NGE_ASSERT_NOW(a_stack_flags, b_stat.stack_full, !b_stat.stack_empty, "stack both full and empty")

endmodule
